[src/nfae_pkg.sv]
`default_nettype none
package nfae_pkg;

    localparam int BLOCK_BYTES = 4096;
    localparam int NUM_BLOCKS  = 16;
    localparam int ARRAY_BYTES = BLOCK_BYTES * NUM_BLOCKS;

    localparam int ADDR_W    = 24;
    localparam int MEM_W     = $clog2(ARRAY_BYTES);
    localparam int BLK_OFF_W = $clog2(BLOCK_BYTES);
    localparam int BLK_IDX_W = MEM_W - BLK_OFF_W;
    localparam int WEAR_W    = 32;

    localparam logic [7:0] ERASED_BYTE = 8'hFF;

    localparam logic [1:0] OP_READ    = 2'd0;
    localparam logic [1:0] OP_PROGRAM = 2'd1;
    localparam logic [1:0] OP_ERASE   = 2'd2;
    localparam logic [1:0] OP_UNUSED  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_ALIGN = 2'd2;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    typedef struct packed {
        logic capture;
        logic fetch;
        logic sweep_init;
        logic sweep_step;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_end;
        logic block_end;
        logic erase_ok;
        logic out_free;
    } dp_status_t;

endpackage
`default_nettype wire

[src/nfae_ctrl.sv]
`default_nettype none
module nfae_ctrl (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       s_tvalid,
    output logic                      s_tready,
    input  wire nfae_pkg::dp_status_t stat,
    output nfae_pkg::ctrl_cmd_t       cmd
);

    typedef enum logic [2:0] {
        CLEAR,
        IDLE,
        FETCH,
        SORT,
        ERASE,
        FIN
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == IDLE);

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        case (state_reg)
            CLEAR: begin
                cmd.sweep_step = 1'b1;
                if (stat.clear_end) begin
                    state_next = IDLE;
                end
            end
            IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = FETCH;
                end
            end
            FETCH: begin
                cmd.fetch  = 1'b1;
                state_next = SORT;
            end
            SORT: begin
                if (stat.erase_ok) begin
                    cmd.sweep_init = 1'b1;
                    state_next     = ERASE;
                end else begin
                    state_next = FIN;
                end
            end
            ERASE: begin
                cmd.sweep_step = 1'b1;
                if (stat.block_end) begin
                    state_next = FIN;
                end
            end
            FIN: begin
                if (stat.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

[src/nfae_datapath.sv]
`default_nettype none
module nfae_datapath (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire  [nfae_pkg::S_TDATA_W-1:0]      s_tdata,
    input  wire                                 s_tlast,
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    output logic [nfae_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tlast,
    input  wire nfae_pkg::ctrl_cmd_t            cmd,
    output nfae_pkg::dp_status_t                stat
);

    logic [7:0] mem [nfae_pkg::ARRAY_BYTES];

    logic [1:0]                     op_reg;
    logic [nfae_pkg::ADDR_W-1:0]    addr_reg;
    logic [7:0]                     wdata_reg;
    logic                           last_reg;
    logic [7:0]                     rd_reg;
    logic [nfae_pkg::MEM_W-1:0]     sweep_reg;
    logic [nfae_pkg::MEM_W-1:0]     sweep_next;
    logic [nfae_pkg::WEAR_W-1:0]    wear_reg [nfae_pkg::NUM_BLOCKS];

    logic                           out_valid_reg;
    logic [7:0]                     out_rdata_reg;
    logic [nfae_pkg::WEAR_W-1:0]    out_wear_reg;
    logic [1:0]                     out_status_reg;
    logic                           out_last_reg;

    logic [nfae_pkg::MEM_W-1:0]     mem_idx;
    logic [nfae_pkg::BLK_IDX_W-1:0] blk_idx;
    logic                           in_range;
    logic                           misaligned;
    logic                           prog_ok;
    logic                           erase_ok;
    logic [nfae_pkg::WEAR_W-1:0]    wear_inc;
    logic [7:0]                     res_rdata;
    logic [nfae_pkg::WEAR_W-1:0]    res_wear;
    logic [1:0]                     res_status;
    logic                           mem_we;
    logic [nfae_pkg::MEM_W-1:0]     mem_wa;
    logic [7:0]                     mem_wd;

    assign mem_idx    = addr_reg[nfae_pkg::MEM_W-1:0];
    assign blk_idx    = mem_idx[nfae_pkg::MEM_W-1:nfae_pkg::BLK_OFF_W];
    assign in_range   = ({8'd0, addr_reg} < 32'(nfae_pkg::ARRAY_BYTES));
    assign misaligned = (addr_reg[nfae_pkg::BLK_OFF_W-1:0] != '0);
    assign prog_ok    = (op_reg == nfae_pkg::OP_PROGRAM) && in_range;
    assign erase_ok   = (op_reg == nfae_pkg::OP_ERASE) && in_range && !misaligned;
    assign wear_inc   = wear_reg[blk_idx] + 32'd1;

    always_comb begin
        res_status = nfae_pkg::ST_OK;
        if ((op_reg != nfae_pkg::OP_UNUSED) && !in_range) begin
            res_status = nfae_pkg::ST_RANGE;
        end else if ((op_reg == nfae_pkg::OP_ERASE) && misaligned) begin
            res_status = nfae_pkg::ST_ALIGN;
        end
        res_rdata = ((op_reg == nfae_pkg::OP_READ) && in_range) ? rd_reg : 8'd0;
        res_wear  = erase_ok ? wear_inc : '0;
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = sweep_reg;
        mem_wd = nfae_pkg::ERASED_BYTE;
        if (cmd.sweep_step) begin
            mem_we = 1'b1;
        end else if (cmd.finish && prog_ok) begin
            mem_we = 1'b1;
            mem_wa = mem_idx;
            mem_wd = rd_reg & wdata_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (cmd.fetch) begin
            rd_reg <= mem[mem_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg    <= s_tdata[1:0];
            addr_reg  <= s_tdata[25:2];
            wdata_reg <= s_tdata[33:26];
            last_reg  <= s_tlast;
        end
    end

    always_comb begin
        sweep_next = sweep_reg;
        if (cmd.sweep_init) begin
            sweep_next = {blk_idx, {nfae_pkg::BLK_OFF_W{1'b0}}};
        end else if (cmd.sweep_step) begin
            sweep_next = sweep_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg <= '0;
        end else begin
            sweep_reg <= sweep_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < nfae_pkg::NUM_BLOCKS; i++) begin
                wear_reg[i] <= '0;
            end
        end else if (cmd.finish && erase_ok) begin
            wear_reg[blk_idx] <= wear_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_rdata_reg  <= res_rdata;
            out_wear_reg   <= res_wear;
            out_status_reg <= res_status;
            out_last_reg   <= last_reg;
        end
    end

    assign stat.clear_end = (sweep_reg == nfae_pkg::MEM_W'(nfae_pkg::ARRAY_BYTES - 1));
    assign stat.block_end = &sweep_reg[nfae_pkg::BLK_OFF_W-1:0];
    assign stat.erase_ok  = erase_ok;
    assign stat.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_status_reg, out_wear_reg, out_rdata_reg};
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire

[src/nor_flash_array_emulator.sv]
// NOR flash array emulator: 16 erase blocks of 4096 bytes, one wear counter per block.
// Slave channel: one request per transfer. tdata carries opcode (0 read, 1 program,
// 2 erase), byte address and write data; tlast marks the last byte of a burst.
// Master channel: exactly one response per request, in order. tdata carries read
// data, wear count and status (0 ok, 1 out of range, 2 misaligned erase); tlast
// echoes the request's tlast.
// A read or program request passes through the capture, array read, decode and
// response steps of the single-port array; the next request is taken only once
// the response is loaded, so one request is in progress at a time.
// An aligned, in-range erase writes the block one byte per cycle before its response.
// After reset the array is swept to 0xFF one byte per cycle; s_tready stays low until
// the whole array is swept. Wear counters clear at once.
// When the receiver stalls, the response waits in the output register; one more
// request is taken and held at its final step until that register frees.
`default_nettype none
module nor_flash_array_emulator (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // opcode[1:0], byte_address[25:2], write_data[33:26], zero fill
    input  wire  [nfae_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire                               s_tlast,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // read_data[7:0], wear_count[39:8], status[41:40], zero fill
    output logic [nfae_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tlast
);

    nfae_pkg::ctrl_cmd_t  cmd;
    nfae_pkg::dp_status_t stat;

    nfae_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    nfae_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule
`default_nettype wire
